// ===== rtl/gha_pkg.sv =====
// Shared constants for the generational handle allocator.
`timescale 1ns / 1ps
`default_nettype none
package gha_pkg;

  // Default pool shape.
  localparam int CAPACITY_DEF     = 256;
  localparam int VERSION_BITS_DEF = 16;

  // Fixed port widths.
  localparam int ACTION_W  = 2;
  localparam int SLOT_IO_W = 8;
  localparam int VER_IO_W  = 16;
  localparam int STATUS_W  = 2;

  // Width of one freed-map word that the scan looks at per cycle.
  localparam int SCAN_W   = 16;
  localparam int SCAN_BIT = 4;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NEVER_ALC = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/generational_handle_allocator_top.sv =====
// Generational handle allocator: slot/version handles with create, remove, lookup.
//
// One input channel carries an action (create, remove, lookup) with a slot and
// a version; one result channel returns a slot, the stored version, a hit flag
// and a status, exactly one result item per input item. Both use valid/ready.
// The block works on one item at a time and is not ready while it does.
// Steps from acceptance until the block is ready again:
//   create of a fresh slot, pool full, out of range, unused action: result out
//   remove or lookup of an allocated slot: version store read, update, result out
//   create that reuses a freed slot: freed-map scan over at most CAPACITY/16
//   16-bit words, then version store read, update, result out.
// The scan looks at one freed-map word per cycle through a shared 16-bit
// priority encoder; the version store has a registered read port.
// Reset clears the freed map, the freed count, the allocated count and all
// control state; the version store is not cleared, since a slot is only
// addressable after create has written it. When the receiver stalls, the
// finished result sits in the output register and the next result waits in
// its own register, so the block accepts one more item meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_allocator_top #(
  parameter int CAPACITY     = gha_pkg::CAPACITY_DEF,
  parameter int VERSION_BITS = gha_pkg::VERSION_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [gha_pkg::ACTION_W-1:0]   in_action,
  input  wire logic [gha_pkg::SLOT_IO_W-1:0]  in_slot_in,
  input  wire logic [gha_pkg::VER_IO_W-1:0]   in_version_in,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [gha_pkg::SLOT_IO_W-1:0]       out_slot_out,
  output logic [gha_pkg::VER_IO_W-1:0]        out_version_out,
  output logic                                out_hit,
  output logic [gha_pkg::STATUS_W-1:0]        out_status
);
  import gha_pkg::*;

  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int NWORD   = (CAPACITY + SCAN_W - 1) / SCAN_W;
  localparam int WIDX_W  = (NWORD > 1) ? $clog2(NWORD) : 1;
  localparam int MAP_W   = (1 << WIDX_W) * SCAN_W;
  localparam int CMP_W   = (CNT_W > SLOT_IO_W) ? CNT_W : SLOT_IO_W;
  localparam int VCMP_W  = (VERSION_BITS > VER_IO_W) ? VERSION_BITS : VER_IO_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // Control state.
  logic [2:0]              state_r, state_nxt;
  logic [MAP_W-1:0]        freed_r, freed_nxt;
  logic [CNT_W-1:0]        freed_cnt_r, freed_cnt_nxt;
  logic [CNT_W-1:0]        used_r, used_nxt;
  logic [WIDX_W-1:0]       word_r, word_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Request and result holding registers.
  logic [ACTION_W-1:0]     act_r, act_nxt;
  logic [VER_IO_W-1:0]     req_ver_r, req_ver_nxt;
  logic [SLOT_W-1:0]       sel_r, sel_nxt;
  logic [SLOT_IO_W-1:0]    res_slot_r, res_slot_nxt;
  logic [VER_IO_W-1:0]     res_ver_r, res_ver_nxt;
  logic                    res_hit_r, res_hit_nxt;
  logic [STATUS_W-1:0]     res_status_r, res_status_nxt;
  logic [SLOT_IO_W-1:0]    out_slot_r, out_slot_nxt;
  logic [VER_IO_W-1:0]     out_ver_r, out_ver_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;

  // Version store.
  logic [VERSION_BITS-1:0] ver_mem [CAPACITY];
  logic [VERSION_BITS-1:0] ver_rd_r;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_waddr;
  logic [VERSION_BITS-1:0] mem_wdata;

  // Scan word and its priority encoder.
  logic [SCAN_W-1:0]       scan_word;
  logic [SCAN_BIT-1:0]     scan_pos;
  logic                    scan_any;
  logic [SLOT_W-1:0]       scan_slot;
  logic [VERSION_BITS-1:0] ver_inc;
  logic                    in_range;

  always_comb begin
    scan_word = freed_r[word_r*SCAN_W +: SCAN_W];
    scan_any  = |scan_word;
    scan_pos  = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (scan_word[i]) begin
        scan_pos = SCAN_BIT'(i);
      end
    end
    scan_slot = SLOT_W'({word_r, scan_pos});
  end

  assign in_range = CMP_W'(in_slot_in) < CMP_W'(used_r);
  assign ver_inc  = ver_rd_r + VERSION_BITS'(1);

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    freed_nxt      = freed_r;
    freed_cnt_nxt  = freed_cnt_r;
    used_nxt       = used_r;
    word_nxt       = word_r;
    act_nxt        = act_r;
    req_ver_nxt    = req_ver_r;
    sel_nxt        = sel_r;
    res_slot_nxt   = res_slot_r;
    res_ver_nxt    = res_ver_r;
    res_hit_nxt    = res_hit_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_ver_nxt    = out_ver_r;
    out_hit_nxt    = out_hit_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = sel_r;
    mem_wdata      = ver_inc;
    in_ready       = (state_r == S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt        = in_action;
          req_ver_nxt    = in_version_in;
          res_slot_nxt   = '0;
          res_ver_nxt    = '0;
          res_hit_nxt    = 1'b0;
          res_status_nxt = ST_OK;
          state_nxt      = S_DONE;
          if (in_action == ACT_CREATE) begin
            if (freed_cnt_r != '0) begin
              word_nxt  = '0;
              state_nxt = S_SCAN;
            end else if (used_r != CNT_W'(CAPACITY)) begin
              // Fresh slot starts at version 1.
              mem_we       = 1'b1;
              mem_waddr    = SLOT_W'(used_r);
              mem_wdata    = VERSION_BITS'(1);
              used_nxt     = used_r + CNT_W'(1);
              res_slot_nxt = SLOT_IO_W'(used_r);
              res_ver_nxt  = VER_IO_W'(VERSION_BITS'(1));
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else if (in_action == ACT_REMOVE || in_action == ACT_LOOKUP) begin
            res_slot_nxt = in_slot_in;
            if (in_range) begin
              sel_nxt   = SLOT_W'(in_slot_in);
              state_nxt = S_READ;
            end else begin
              res_status_nxt = ST_NEVER_ALC;
            end
          end
        end
      end
      S_SCAN: begin
        // One freed-map word per cycle; the lowest set bit wins.
        if (scan_any) begin
          sel_nxt              = scan_slot;
          freed_nxt[scan_slot] = 1'b0;
          freed_cnt_nxt        = freed_cnt_r - CNT_W'(1);
          state_nxt            = S_READ;
        end else begin
          word_nxt = word_r + WIDX_W'(1);
        end
      end
      S_READ: begin
        // Version store read of sel_r lands in ver_rd_r.
        state_nxt = S_UPD;
      end
      S_UPD: begin
        res_slot_nxt = SLOT_IO_W'(sel_r);
        res_ver_nxt  = VER_IO_W'(ver_rd_r);
        state_nxt    = S_DONE;
        if (act_r == ACT_CREATE) begin
          mem_we      = 1'b1;
          res_ver_nxt = VER_IO_W'(ver_inc);
        end else if (act_r == ACT_REMOVE) begin
          if (!freed_r[sel_r]) begin
            freed_nxt[sel_r] = 1'b1;
            freed_cnt_nxt    = freed_cnt_r + CNT_W'(1);
          end
        end else begin
          res_hit_nxt = !freed_r[sel_r] &&
                        (VCMP_W'(ver_rd_r) == VCMP_W'(req_ver_r));
        end
      end
      S_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = res_slot_r;
          out_ver_nxt    = res_ver_r;
          out_hit_nxt    = res_hit_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      freed_r     <= '0;
      freed_cnt_r <= '0;
      used_r      <= '0;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      freed_r     <= freed_nxt;
      freed_cnt_r <= freed_cnt_nxt;
      used_r      <= used_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    req_ver_r    <= req_ver_nxt;
    sel_r        <= sel_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ver_r    <= res_ver_nxt;
    res_hit_r    <= res_hit_nxt;
    res_status_r <= res_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ver_r    <= out_ver_nxt;
    out_hit_r    <= out_hit_nxt;
    out_status_r <= out_status_nxt;
  end

  // Version store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ver_mem[mem_waddr] <= mem_wdata;
    end
    ver_rd_r <= ver_mem[sel_r];
  end

  assign out_valid       = out_valid_r;
  assign out_slot_out    = out_slot_r;
  assign out_version_out = out_ver_r;
  assign out_hit         = out_hit_r;
  assign out_status      = out_status_r;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the generational handle allocator.
`timescale 1ns / 1ps
module tb_top;
  import gha_pkg::*;

  // Action 3 is not defined by the block and must change nothing.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int POOL_SIZE = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [SLOT_IO_W-1:0] slot;
    logic [VER_IO_W-1:0]  version;
    logic                 hit;
    logic [STATUS_W-1:0]  status;
  } handle_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ACTION_W-1:0]  in_action = ACT_CREATE;
  logic [SLOT_IO_W-1:0] in_slot_in = '0;
  logic [VER_IO_W-1:0]  in_version_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SLOT_IO_W-1:0] out_slot_out;
  logic [VER_IO_W-1:0]  out_version_out;
  logic                 out_hit;
  logic [STATUS_W-1:0]  out_status;

  // Shadow copy of the allocator state.
  logic                freed_flag [POOL_SIZE];
  logic [VER_IO_W-1:0] slot_ver [POOL_SIZE];
  int                  alloc_count = 0;

  handle_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int recv_hold_cycles = 0;

  generational_handle_allocator_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_slot_in     (in_slot_in),
    .in_version_in  (in_version_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slot_out   (out_slot_out),
    .out_version_out(out_version_out),
    .out_hit        (out_hit),
    .out_status     (out_status)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      out_ready <= 1'b0;
      recv_hold_cycles--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Apply one item to the shadow state and return the result it must give.
  function automatic handle_result_t apply_action(input logic [ACTION_W-1:0] act,
                                                  input logic [SLOT_IO_W-1:0] slot,
                                                  input logic [VER_IO_W-1:0] ver);
    handle_result_t r;
    int idx;
    r = '0;
    idx = -1;
    case (act)
      ACT_CREATE: begin
        // Lowest freed slot wins; otherwise take the next fresh slot.
        for (int i = 0; i < alloc_count; i++) begin
          if (freed_flag[i] && idx < 0) idx = i;
        end
        if (idx >= 0) begin
          freed_flag[idx] = 1'b0;
          slot_ver[idx] = slot_ver[idx] + 1'b1;
          r.slot = idx[SLOT_IO_W-1:0];
          r.version = slot_ver[idx];
        end else if (alloc_count < POOL_SIZE) begin
          idx = alloc_count;
          slot_ver[idx] = VER_IO_W'(1);
          freed_flag[idx] = 1'b0;
          alloc_count++;
          r.slot = idx[SLOT_IO_W-1:0];
          r.version = slot_ver[idx];
        end else begin
          r.status = ST_FULL;
        end
      end
      ACT_REMOVE, ACT_LOOKUP: begin
        r.slot = slot;
        if (int'(slot) >= alloc_count) begin
          r.status = ST_NEVER_ALC;
        end else begin
          r.version = slot_ver[slot];
          if (act == ACT_REMOVE) begin
            freed_flag[slot] = 1'b1;
          end else begin
            r.hit = !freed_flag[slot] && (slot_ver[slot] == ver);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item, with an optional idle gap first, and record its result.
  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic [SLOT_IO_W-1:0] slot,
                           input logic [VER_IO_W-1:0] ver);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_slot_in <= slot;
    in_version_in <= ver;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_action(act, slot, ver));
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // One random item, mostly aimed at live slots with plausible versions.
  task automatic send_random_item();
    logic [ACTION_W-1:0] act;
    logic [SLOT_IO_W-1:0] slot;
    logic [VER_IO_W-1:0] ver;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) act = ACT_CREATE;
    else if (pick < 55) act = ACT_REMOVE;
    else if (pick < 95) act = ACT_LOOKUP;
    else act = ACT_UNUSED;
    if (alloc_count > 0 && $urandom_range(99) < 75)
      slot = SLOT_IO_W'($urandom_range(alloc_count - 1));
    else
      slot = SLOT_IO_W'($urandom_range(255));
    ver = VER_IO_W'($urandom_range(16'hFFFF));
    if (act == ACT_LOOKUP && int'(slot) < alloc_count) begin
      pick = $urandom_range(99);
      if (pick < 60) ver = slot_ver[slot];
      else if (pick < 75) ver = slot_ver[slot] + 1'b1;
    end
    send_item(act, slot, ver);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
    drain_results();
  endtask

  // Short hand-picked sequence from reset: every action and corner.
  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(ACT_LOOKUP, 8'd0, 16'd0);        // nothing allocated yet
    send_item(ACT_REMOVE, 8'd255, 16'hFFFF);
    send_item(ACT_UNUSED, 8'd255, 16'hFFFF);
    send_item(ACT_CREATE, 8'd0, 16'd0);
    send_item(ACT_CREATE, 8'd255, 16'hFFFF);
    send_item(ACT_CREATE, 8'd0, 16'd0);
    send_item(ACT_LOOKUP, 8'd0, 16'd1);        // live handle hits
    send_item(ACT_LOOKUP, 8'd0, 16'hFFFF);     // stale version misses
    send_item(ACT_LOOKUP, 8'd3, 16'd1);        // first slot past the used range
    send_item(ACT_REMOVE, 8'd1, 16'd0);
    send_item(ACT_REMOVE, 8'd1, 16'd0);        // second remove has no effect
    send_item(ACT_LOOKUP, 8'd1, 16'd1);        // freed slot never hits
    send_item(ACT_REMOVE, 8'd0, 16'd0);
    send_item(ACT_CREATE, 8'd0, 16'd0);        // reuses the lowest freed slot
    send_item(ACT_CREATE, 8'd0, 16'd0);
    send_item(ACT_CREATE, 8'd0, 16'd0);        // fresh slot again
    send_item(ACT_LOOKUP, 8'd1, 16'd2);
    send_item(ACT_UNUSED, 8'd0, 16'd0);
    drain_results();
  endtask

  // Fill the pool, run into pool full, and reuse slots at the top of the map.
  task automatic test_pool_full();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (alloc_count < POOL_SIZE)
      send_item(ACT_CREATE, SLOT_IO_W'($urandom_range(255)),
                VER_IO_W'($urandom_range(16'hFFFF)));
    // The fill loop has taken up any freed slots, so these creates report full.
    repeat (3) send_item(ACT_CREATE, 8'd0, 16'd0);
    drain_results();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (freed_flag[i]) send_item(ACT_CREATE, 8'd0, 16'd0);
    end
    send_item(ACT_CREATE, 8'd0, 16'd0);
    send_item(ACT_REMOVE, 8'd255, 16'd0);
    send_item(ACT_REMOVE, 8'd254, 16'd0);
    send_item(ACT_CREATE, 8'd0, 16'd0);        // scan runs over the whole map
    send_item(ACT_CREATE, 8'd0, 16'd0);
    send_item(ACT_CREATE, 8'd0, 16'd0);
    send_item(ACT_LOOKUP, 8'd255, slot_ver[255]);
    drain_results();
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    recv_hold_cycles = 300;
    repeat (12) send_random_item();
    drain_results();
    repeat (8) send_random_item();
    drain_results();
  endtask

  // Cycle slot 0 through remove and create; each reuse advances its version.
  task automatic test_slot_reuse();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) begin
      send_item(ACT_REMOVE, 8'd0, 16'd0);
      send_item(ACT_CREATE, 8'd0, 16'd0);
      send_item(ACT_LOOKUP, 8'd0, slot_ver[0]);
    end
    send_item(ACT_LOOKUP, 8'd0, slot_ver[0] - 1'b1);   // previous handle misses
    drain_results();
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    handle_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: slot_out %0d status %0d", out_slot_out, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_slot_out !== want.slot) begin
          $error("slot_out: expected %0d, got %0d", want.slot, out_slot_out);
          error_count++;
        end
        if (out_version_out !== want.version) begin
          $error("version_out: expected %0d, got %0d", want.version, out_version_out);
          error_count++;
        end
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          error_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    foreach (freed_flag[i]) freed_flag[i] = 1'b0;
    foreach (slot_ver[i]) slot_ver[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    run_random_phase(0, 0, 300);
    run_random_phase(70, 0, 300);
    test_pool_full();
    run_random_phase(0, 70, 400);
    run_random_phase(32, 32, 400);
    test_backpressure();
    test_slot_reuse();
    drain_results();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
